[design/brts_pkg.sv]
// Shared constants, types and codes of the bilinear RGB texture sampler.
package brts_pkg;

    // Image geometry and coordinate format
    localparam int IMG_W     = 256;
    localparam int IMG_H     = 256;
    localparam int FRAC_BITS = 8;
    localparam int COORD_W   = 18;
    localparam int LOAD_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int NCHAN     = 3;
    localparam int PIX_W     = CHAN_W * NCHAN;

    localparam int COL_W     = $clog2(IMG_W);
    localparam int ROW_W     = $clog2(IMG_H);
    localparam int INT_W     = COORD_W - FRAC_BITS;
    localparam int LD_CMP_W  = 14;

    // Four banks split by row and column parity
    localparam int NBANK      = 4;
    localparam int BANK_SEL_W = 2;
    localparam int BANK_AW    = (ROW_W - 1) + (COL_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam int HSUM_W = CHAN_W + FRAC_BITS;
    localparam int VSUM_W = CHAN_W + 2 * FRAC_BITS;

    typedef logic [COORD_W-1:0]    t_coord;
    typedef logic [INT_W-1:0]      t_int;
    typedef logic [COL_W-1:0]      t_col;
    typedef logic [ROW_W-1:0]      t_row;
    typedef logic [LD_CMP_W-1:0]   t_ldcmp;
    typedef logic [FRAC_BITS-1:0]  t_frac;
    typedef logic [FRAC_BITS:0]    t_wgt;
    typedef logic [CHAN_W-1:0]     t_chan;
    typedef logic [PIX_W-1:0]      t_pix;
    typedef logic [BANK_AW-1:0]    t_bank_addr;
    typedef logic [BANK_SEL_W-1:0] t_bsel;
    typedef logic [HSUM_W-1:0]     t_hsum;
    typedef logic [HSUM_W:0]       t_hprod;
    typedef logic [VSUM_W:0]       t_vprod;

    localparam t_coord XMAX     = t_coord'(IMG_W) << FRAC_BITS;
    localparam t_coord YMAX     = t_coord'(IMG_H) << FRAC_BITS;
    localparam t_wgt   WGT_ONE  = t_wgt'(1) << FRAC_BITS;
    localparam t_chan  CHAN_MAX = '1;

    // Item action codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Sample control carried from address generation to the blend stages
    typedef struct packed {
        logic  white;
        t_frac fx;
        t_frac fy;
        logic  px;
        logic  py;
        logic  xsame;
        logic  ysame;
    } t_s1_ctrl;

endpackage

[design/brts_in_if.sv]
// Input channel of the texture sampler: load and sample items.
interface brts_in_if;
    logic                            valid;
    logic                            ready;
    logic                            action;
    logic [brts_pkg::LOAD_W-1:0]     load_col;
    logic [brts_pkg::LOAD_W-1:0]     load_row;
    logic [brts_pkg::CHAN_W-1:0]     load_red;
    logic [brts_pkg::CHAN_W-1:0]     load_green;
    logic [brts_pkg::CHAN_W-1:0]     load_blue;
    logic signed [brts_pkg::COORD_W-1:0] sample_x;
    logic signed [brts_pkg::COORD_W-1:0] sample_y;

    modport source (
        output valid, action, load_col, load_row, load_red, load_green, load_blue,
        output sample_x, sample_y,
        input  ready
    );
    modport sink (
        input  valid, action, load_col, load_row, load_red, load_green, load_blue,
        input  sample_x, sample_y,
        output ready
    );
endinterface

[design/brts_out_if.sv]
// Output channel of the texture sampler: blended RGB results.
interface brts_out_if;
    logic                        valid;
    logic                        ready;
    logic [brts_pkg::CHAN_W-1:0] red;
    logic [brts_pkg::CHAN_W-1:0] green;
    logic [brts_pkg::CHAN_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

[design/bilinear_rgb_texture_sampler.sv]
// Bilinear RGB texture sampler: top level with banked texture store and 3-stage pipeline.
// Each result passes the bank read, horizontal blend and vertical blend registers in turn.
// One item per cycle unless o_out stalls; each of the four banks gives one read a cycle.
// An in-range load writes its pixel through a bank write port; loads yield no result.
// Reset clears only the pipeline valid bits; texture contents are undefined until loaded.
module bilinear_rgb_texture_sampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brts_in_if.sink     i_in,
    brts_out_if.source  o_out
);
    // Pipeline handshake. Each stage moves when it is empty or the stage after
    // it moves, so bubbles collapse and the input can keep taking items, until
    // the empty stages fill, while a finished result waits in the output register.
    logic w_adv1, w_adv2, w_adv3;
    logic w_acc, w_is_smp;
    logic r_v1, r_v2, r_v3;

    assign w_adv3   = !r_v3 || o_out.ready;
    assign w_adv2   = !r_v2 || w_adv3;
    assign w_adv1   = !r_v1 || w_adv2;
    assign i_in.ready = w_adv1;
    assign w_acc    = i_in.valid && w_adv1;
    assign w_is_smp = (i_in.action == brts_pkg::ACT_SAMPLE);

    // Stage 0: address generation. The texture is split into four banks by
    // row and column parity, so the 2x2 neighbourhood always hits each bank
    // at most once; a clamped neighbour reuses its partner's bank.
    brts_pkg::t_bank_addr w_rd_addr [brts_pkg::NBANK];
    brts_pkg::t_s1_ctrl   w_ctrl;
    logic                 w_wr_ok;
    brts_pkg::t_bsel      w_wr_bank;
    brts_pkg::t_bank_addr w_wr_addr;

    brts_addr u_addr (
        .i_load_col (i_in.load_col),
        .i_load_row (i_in.load_row),
        .i_sample_x (i_in.sample_x),
        .i_sample_y (i_in.sample_y),
        .o_rd_addr  (w_rd_addr),
        .o_ctrl     (w_ctrl),
        .o_wr_ok    (w_wr_ok),
        .o_wr_bank  (w_wr_bank),
        .o_wr_addr  (w_wr_addr)
    );

    // Stage 1: bank reads. Writes and reads issue at the same point in item
    // order, so a sample right after a load sees the new pixel.
    brts_pkg::t_pix w_bank [brts_pkg::NBANK];
    brts_pkg::t_pix w_wdata;

    assign w_wdata = {i_in.load_red, i_in.load_green, i_in.load_blue};

    for (genvar k = 0; k < brts_pkg::NBANK; k++) begin : g_bank
        brts_ram #(
            .WIDTH (brts_pkg::PIX_W),
            .DEPTH (brts_pkg::BANK_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_acc && !w_is_smp && w_wr_ok
                      && (w_wr_bank == brts_pkg::t_bsel'(k))),
            .i_waddr (w_wr_addr),
            .i_wdata (w_wdata),
            .i_re    (w_acc && w_is_smp),
            .i_raddr (w_rd_addr[k]),
            .o_rdata (w_bank[k])
        );
    end

    // Sample control rides alongside the bank read data
    brts_pkg::t_s1_ctrl r_s1;

    always_ff @(posedge i_clk) begin
        if (w_acc && w_is_smp) begin
            r_s1 <= w_ctrl;
        end
    end

    // Valid bits; loads leave a bubble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_acc && w_is_smp;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 2: horizontal blend of top and bottom pairs
    brts_pkg::t_hsum w_top [brts_pkg::NCHAN];
    brts_pkg::t_hsum w_bot [brts_pkg::NCHAN];
    brts_pkg::t_frac w_fy2;
    logic            w_white2;

    brts_hblend u_hblend (
        .i_clk   (i_clk),
        .i_en    (w_adv2 && r_v1),
        .i_bank  (w_bank),
        .i_ctrl  (r_s1),
        .o_top   (w_top),
        .o_bot   (w_bot),
        .o_fy    (w_fy2),
        .o_white (w_white2)
    );

    // Stage 3: vertical blend into the output register
    brts_vblend u_vblend (
        .i_clk   (i_clk),
        .i_en    (w_adv3 && r_v2),
        .i_top   (w_top),
        .i_bot   (w_bot),
        .i_fy    (w_fy2),
        .i_white (w_white2),
        .o_red   (o_out.red),
        .o_green (o_out.green),
        .o_blue  (o_out.blue)
    );

    assign o_out.valid = r_v3;

    // A sample transfer always occupies stage 1 next cycle
    a_smp_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_is_smp) |=> r_v1)
        else $error("sample transfer did not enter fetch stage");

    // A stalled fetch stage keeps its item and control
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv1 |=> (r_v1 && $stable(r_s1)))
        else $error("fetch stage lost or changed item during stall");

    // Out-of-range samples come out white
    a_white_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_adv3 && w_white2) |=>
            ((o_out.red == brts_pkg::CHAN_MAX) && (o_out.green == brts_pkg::CHAN_MAX)
             && (o_out.blue == brts_pkg::CHAN_MAX)))
        else $error("out-of-range sample not white");
endmodule

[design/brts_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
module brts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[design/brts_addr.sv]
// Range check, edge clamp and per-bank address generation for loads and samples.
module brts_addr (
    input  logic [brts_pkg::LOAD_W-1:0]      i_load_col,
    input  logic [brts_pkg::LOAD_W-1:0]      i_load_row,
    input  logic signed [brts_pkg::COORD_W-1:0] i_sample_x,
    input  logic signed [brts_pkg::COORD_W-1:0] i_sample_y,
    output brts_pkg::t_bank_addr             o_rd_addr [brts_pkg::NBANK],
    output brts_pkg::t_s1_ctrl               o_ctrl,
    output logic                             o_wr_ok,
    output brts_pkg::t_bsel                  o_wr_bank,
    output brts_pkg::t_bank_addr             o_wr_addr
);
    brts_pkg::t_coord w_ux, w_uy;
    brts_pkg::t_int   w_xi, w_yi;
    brts_pkg::t_col   w_x0, w_x1, w_lcol;
    brts_pkg::t_row   w_y0, w_y1, w_lrow;
    logic             w_xsame, w_ysame, w_out_x, w_out_y;

    always_comb begin
        w_ux = brts_pkg::t_coord'(i_sample_x);
        w_uy = brts_pkg::t_coord'(i_sample_y);
        // negative or past the far edge gives white
        w_out_x = w_ux[brts_pkg::COORD_W-1] || (w_ux > brts_pkg::XMAX);
        w_out_y = w_uy[brts_pkg::COORD_W-1] || (w_uy > brts_pkg::YMAX);
        w_xi = w_ux[brts_pkg::COORD_W-1:brts_pkg::FRAC_BITS];
        w_yi = w_uy[brts_pkg::COORD_W-1:brts_pkg::FRAC_BITS];
        w_x0 = (w_xi > brts_pkg::t_int'(brts_pkg::IMG_W - 1))
             ? brts_pkg::t_col'(brts_pkg::IMG_W - 1) : w_xi[brts_pkg::COL_W-1:0];
        w_y0 = (w_yi > brts_pkg::t_int'(brts_pkg::IMG_H - 1))
             ? brts_pkg::t_row'(brts_pkg::IMG_H - 1) : w_yi[brts_pkg::ROW_W-1:0];
        // right / lower neighbour clamps to the last column / row
        w_xsame = (w_x0 == brts_pkg::t_col'(brts_pkg::IMG_W - 1));
        w_ysame = (w_y0 == brts_pkg::t_row'(brts_pkg::IMG_H - 1));
        w_x1 = w_xsame ? w_x0 : w_x0 + brts_pkg::t_col'(1);
        w_y1 = w_ysame ? w_y0 : w_y0 + brts_pkg::t_row'(1);
    end

    always_comb begin
        brts_pkg::t_bsel bs;
        brts_pkg::t_col  csel;
        brts_pkg::t_row  rsel;
        for (int b = 0; b < brts_pkg::NBANK; b++) begin
            bs   = brts_pkg::t_bsel'(b);
            rsel = (w_y0[0] == bs[1]) ? w_y0 : w_y1;
            csel = (w_x0[0] == bs[0]) ? w_x0 : w_x1;
            o_rd_addr[b] = {rsel[brts_pkg::ROW_W-1:1], csel[brts_pkg::COL_W-1:1]};
        end
    end

    always_comb begin
        o_ctrl.white = w_out_x || w_out_y;
        o_ctrl.fx    = w_ux[brts_pkg::FRAC_BITS-1:0];
        o_ctrl.fy    = w_uy[brts_pkg::FRAC_BITS-1:0];
        o_ctrl.px    = w_x0[0];
        o_ctrl.py    = w_y0[0];
        o_ctrl.xsame = w_xsame;
        o_ctrl.ysame = w_ysame;
    end

    always_comb begin
        w_lcol    = brts_pkg::t_col'(i_load_col);
        w_lrow    = brts_pkg::t_row'(i_load_row);
        o_wr_ok   = (brts_pkg::t_ldcmp'(i_load_col) < brts_pkg::t_ldcmp'(brts_pkg::IMG_W))
                 && (brts_pkg::t_ldcmp'(i_load_row) < brts_pkg::t_ldcmp'(brts_pkg::IMG_H));
        o_wr_bank = {w_lrow[0], w_lcol[0]};
        o_wr_addr = {w_lrow[brts_pkg::ROW_W-1:1], w_lcol[brts_pkg::COL_W-1:1]};
    end
endmodule

[design/brts_hblend.sv]
// Bank-to-neighbour routing and horizontal blend of the top and bottom pixel pairs.
module brts_hblend (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  brts_pkg::t_pix       i_bank [brts_pkg::NBANK],
    input  brts_pkg::t_s1_ctrl   i_ctrl,
    output brts_pkg::t_hsum      o_top [brts_pkg::NCHAN],
    output brts_pkg::t_hsum      o_bot [brts_pkg::NCHAN],
    output brts_pkg::t_frac      o_fy,
    output logic                 o_white
);
    brts_pkg::t_pix  w_p00, w_p01, w_p10, w_p11;
    brts_pkg::t_wgt  w_wx0, w_wx1;
    brts_pkg::t_hsum n_top [brts_pkg::NCHAN];
    brts_pkg::t_hsum n_bot [brts_pkg::NCHAN];
    brts_pkg::t_hsum r_top [brts_pkg::NCHAN];
    brts_pkg::t_hsum r_bot [brts_pkg::NCHAN];
    brts_pkg::t_frac r_fy;
    logic            r_white;

    always_comb begin
        logic px1, py1;
        px1   = i_ctrl.xsame ? i_ctrl.px : !i_ctrl.px;
        py1   = i_ctrl.ysame ? i_ctrl.py : !i_ctrl.py;
        w_p00 = i_bank[{i_ctrl.py, i_ctrl.px}];
        w_p01 = i_bank[{i_ctrl.py, px1}];
        w_p10 = i_bank[{py1, i_ctrl.px}];
        w_p11 = i_bank[{py1, px1}];
        w_wx1 = brts_pkg::t_wgt'(i_ctrl.fx);
        w_wx0 = brts_pkg::WGT_ONE - w_wx1;
    end

    always_comb begin
        brts_pkg::t_chan a, b, c, d;
        for (int k = 0; k < brts_pkg::NCHAN; k++) begin
            // channel 0 is red in the top byte
            a = w_p00[brts_pkg::PIX_W-1-k*brts_pkg::CHAN_W -: brts_pkg::CHAN_W];
            b = w_p01[brts_pkg::PIX_W-1-k*brts_pkg::CHAN_W -: brts_pkg::CHAN_W];
            c = w_p10[brts_pkg::PIX_W-1-k*brts_pkg::CHAN_W -: brts_pkg::CHAN_W];
            d = w_p11[brts_pkg::PIX_W-1-k*brts_pkg::CHAN_W -: brts_pkg::CHAN_W];
            n_top[k] = brts_pkg::t_hsum'(
                brts_pkg::t_hprod'(a) * brts_pkg::t_hprod'(w_wx0) +
                brts_pkg::t_hprod'(b) * brts_pkg::t_hprod'(w_wx1));
            n_bot[k] = brts_pkg::t_hsum'(
                brts_pkg::t_hprod'(c) * brts_pkg::t_hprod'(w_wx0) +
                brts_pkg::t_hprod'(d) * brts_pkg::t_hprod'(w_wx1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_fy    <= i_ctrl.fy;
            r_white <= i_ctrl.white;
        end
    end

    assign o_top   = r_top;
    assign o_bot   = r_bot;
    assign o_fy    = r_fy;
    assign o_white = r_white;
endmodule

[design/brts_vblend.sv]
// Vertical blend, truncation and white substitution into the output register.
module brts_vblend (
    input  logic               i_clk,
    input  logic               i_en,
    input  brts_pkg::t_hsum    i_top [brts_pkg::NCHAN],
    input  brts_pkg::t_hsum    i_bot [brts_pkg::NCHAN],
    input  brts_pkg::t_frac    i_fy,
    input  logic               i_white,
    output brts_pkg::t_chan    o_red,
    output brts_pkg::t_chan    o_green,
    output brts_pkg::t_chan    o_blue
);
    brts_pkg::t_wgt  w_wy0, w_wy1;
    brts_pkg::t_chan n_chan [brts_pkg::NCHAN];
    brts_pkg::t_chan r_chan [brts_pkg::NCHAN];

    always_comb begin
        brts_pkg::t_vprod v;
        w_wy1 = brts_pkg::t_wgt'(i_fy);
        w_wy0 = brts_pkg::WGT_ONE - w_wy1;
        for (int k = 0; k < brts_pkg::NCHAN; k++) begin
            v = brts_pkg::t_vprod'(i_top[k]) * brts_pkg::t_vprod'(w_wy0)
              + brts_pkg::t_vprod'(i_bot[k]) * brts_pkg::t_vprod'(w_wy1);
            n_chan[k] = i_white ? brts_pkg::CHAN_MAX
                                : v[2*brts_pkg::FRAC_BITS +: brts_pkg::CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_chan <= n_chan;
        end
    end

    assign o_red   = r_chan[0];
    assign o_green = r_chan[1];
    assign o_blue  = r_chan[2];
endmodule
